// File: hdl/cvp_pkg.sv
// Shared types and constants for the clip test / perspective divide / viewport block.
package cvp_pkg;

    localparam int CW    = 32;
    localparam int DW    = 13;
    localparam int LANES = 4;

    localparam int LANE_X   = 0;
    localparam int LANE_Y   = 1;
    localparam int LANE_Z   = 2;
    localparam int LANE_ONE = 3;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    localparam logic [DW-1:0] WIDTH_RESET  = DW'(640);
    localparam logic [DW-1:0] HEIGHT_RESET = DW'(480);

    localparam logic [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

    typedef struct packed {
        logic signed [CW-1:0] clip_x;
        logic signed [CW-1:0] clip_y;
        logic signed [CW-1:0] clip_z;
        logic signed [CW-1:0] clip_w;
    } vertex_t;

    typedef struct packed {
        logic                 inside_res;
        logic signed [CW-1:0] device_x;
        logic signed [CW-1:0] device_y;
        logic signed [CW-1:0] depth;
        logic signed [CW-1:0] inv_w;
        logic                 range_error;
    } result_t;

    // per-word control riding along the divider chain
    typedef struct packed {
        logic             valid;
        logic [LANES-1:0] neg;
        logic [LANES-1:0] nneg;
        logic [LANES-1:0] nzero;
        logic             wzero;
        logic             in_volume;
    } ctl_t;

endpackage

// File: hdl/clip_test_perspective_viewport.sv
// Top level: clip test, four-lane divider cell chain, viewport mapping.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-----------------------------
//  vertex   | start / busy       | vertex  (cvp_pkg::vertex_t)
//  result   | done (one cycle)   | result  (cvp_pkg::result_t)
//  config   | cfg_wr / cfg_addr  | cfg_data (13 bits)
//
// One word per clock; busy stays low. The path is one input stage, one divider cell
// per quotient bit and three output stages.
// Reset clears the valid chain and loads 640 x 480; no clearing pass.
// Results cannot be stalled.
module clip_test_perspective_viewport #(
    parameter int FRAC_BITS = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  cvp_pkg::vertex_t         vertex,
    output logic                     done,
    output cvp_pkg::result_t         result,
    input  logic                     cfg_wr,
    input  logic                     cfg_addr,
    input  logic [cvp_pkg::DW-1:0]   cfg_data
);

    localparam int CW  = cvp_pkg::CW;
    localparam int QW  = CW + FRAC_BITS;
    localparam int LAT = QW + 4;

    logic [cvp_pkg::DW-1:0] width_reg, height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= cvp_pkg::WIDTH_RESET;
            height_reg <= cvp_pkg::HEIGHT_RESET;
        end
        else if (cfg_wr)
        begin
            case (cfg_addr)
                cvp_pkg::REG_WIDTH:  width_reg  <= cfg_data;
                cvp_pkg::REG_HEIGHT: height_reg <= cfg_data;
                default:             width_reg  <= width_reg;
            endcase
        end
    end

    assign busy = 1'b0;

    // input stage
    cvp_pkg::ctl_t                         ctl_s [0:QW];
    logic [CW-1:0]                         div_s [0:QW];
    logic [cvp_pkg::LANES-1:0][CW-1:0]     rem_s [0:QW];
    logic [cvp_pkg::LANES-1:0][QW-1:0]     nq_s  [0:QW];

    cvp_pkg::ctl_t                         ctl_next;
    logic [CW-1:0]                         div_next;
    logic [cvp_pkg::LANES-1:0][QW-1:0]     nq_next;
    logic signed [CW:0]                    xe, ye, ze, we;
    logic [cvp_pkg::LANES-1:0][CW-1:0]     num;
    cvp_pkg::ctl_t                         ctl0_reg;
    logic [CW-1:0]                         div0_reg;
    logic [cvp_pkg::LANES-1:0][QW-1:0]     nq0_reg;

    always_comb
    begin
        xe = {vertex.clip_x[CW-1], vertex.clip_x};
        ye = {vertex.clip_y[CW-1], vertex.clip_y};
        ze = {vertex.clip_z[CW-1], vertex.clip_z};
        we = {vertex.clip_w[CW-1], vertex.clip_w};
        num[cvp_pkg::LANE_X]   = vertex.clip_x;
        num[cvp_pkg::LANE_Y]   = vertex.clip_y;
        num[cvp_pkg::LANE_Z]   = vertex.clip_z;
        num[cvp_pkg::LANE_ONE] = CW'(1) << FRAC_BITS;
        ctl_next.valid     = start & ~busy;
        ctl_next.wzero     = ~(|vertex.clip_w);
        ctl_next.in_volume = (xe > -we) && (xe < we) && (ye > -we) && (ye < we)
                             && (ze > 0) && (ze < we);
        div_next = vertex.clip_w[CW-1] ? CW'(-vertex.clip_w) : vertex.clip_w;
        for (int l = 0; l < cvp_pkg::LANES; l++)
        begin
            ctl_next.nneg[l]  = num[l][CW-1];
            ctl_next.nzero[l] = ~(|num[l]);
            ctl_next.neg[l]   = num[l][CW-1] ^ vertex.clip_w[CW-1];
            nq_next[l] = {(num[l][CW-1] ? CW'(-num[l]) : num[l]), {FRAC_BITS{1'b0}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl0_reg <= '0;
        end
        else
        begin
            ctl0_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div0_reg <= div_next;
        nq0_reg  <= nq_next;
    end

    assign ctl_s[0] = ctl0_reg;
    assign div_s[0] = div0_reg;
    assign rem_s[0] = '0;
    assign nq_s[0]  = nq0_reg;

    for (genvar i = 0; i < QW; i++)
    begin : g_cell
        cvp_cell #(
            .QW(QW)
        ) u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctl_in (ctl_s[i]),
            .div_in (div_s[i]),
            .rem_in (rem_s[i]),
            .nq_in  (nq_s[i]),
            .ctl_out(ctl_s[i+1]),
            .div_out(div_s[i+1]),
            .rem_out(rem_s[i+1]),
            .nq_out (nq_s[i+1])
        );
    end

    cvp_post #(
        .FRAC_BITS(FRAC_BITS),
        .QW       (QW)
    ) u_post (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl_s[QW]),
        .nq           (nq_s[QW]),
        .device_width (width_reg),
        .device_height(height_reg),
        .result       (result),
        .done         (done)
    );

    // every result word must trace back to an accepted start
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start & ~busy, LAT))
        else $error("result word without matching start");

    // a vertex inside the volume has depth in [0, 1)
    a_inside_depth: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.inside_res |->
            !result.depth[CW-1] && (result.depth < (CW'(1) << FRAC_BITS)))
        else $error("inside vertex with depth out of range");

    // inside implies positive w, so 1/w is not negative
    a_inside_invw: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.inside_res |-> !result.inv_w[CW-1])
        else $error("inside vertex with negative inv_w");

endmodule

// File: hdl/cvp_cell.sv
// One restoring-division cell: produces one quotient bit for each of the four lanes.
module cvp_cell #(
    parameter int QW = 48
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  cvp_pkg::ctl_t                         ctl_in,
    input  logic [cvp_pkg::CW-1:0]                div_in,
    input  logic [cvp_pkg::LANES-1:0][cvp_pkg::CW-1:0] rem_in,
    input  logic [cvp_pkg::LANES-1:0][QW-1:0]     nq_in,
    output cvp_pkg::ctl_t                         ctl_out,
    output logic [cvp_pkg::CW-1:0]                div_out,
    output logic [cvp_pkg::LANES-1:0][cvp_pkg::CW-1:0] rem_out,
    output logic [cvp_pkg::LANES-1:0][QW-1:0]     nq_out
);

    cvp_pkg::ctl_t                                 ctl_reg;
    logic [cvp_pkg::CW-1:0]                        div_reg;
    logic [cvp_pkg::LANES-1:0][cvp_pkg::CW-1:0]    rem_reg, rem_next;
    logic [cvp_pkg::LANES-1:0][QW-1:0]             nq_reg, nq_next;

    always_comb
    begin
        logic [cvp_pkg::CW:0] t;
        logic                 ge;
        for (int l = 0; l < cvp_pkg::LANES; l++)
        begin
            t  = {rem_in[l], nq_in[l][QW-1]};
            ge = (t >= {1'b0, div_in});
            rem_next[l] = ge ? cvp_pkg::CW'(t - {1'b0, div_in}) : t[cvp_pkg::CW-1:0];
            nq_next[l]  = {nq_in[l][QW-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg <= div_in;
        rem_reg <= rem_next;
        nq_reg  <= nq_next;
    end

    assign ctl_out = ctl_reg;
    assign div_out = div_reg;
    assign rem_out = rem_reg;
    assign nq_out  = nq_reg;

endmodule

// File: hdl/cvp_post.sv
// Quotient saturation, viewport scale and final halving, three register stages.
module cvp_post #(
    parameter int FRAC_BITS = 16,
    parameter int QW        = 48
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  cvp_pkg::ctl_t                     ctl,
    input  logic [cvp_pkg::LANES-1:0][QW-1:0] nq,
    input  logic [cvp_pkg::DW-1:0]            device_width,
    input  logic [cvp_pkg::DW-1:0]            device_height,
    output cvp_pkg::result_t                  result,
    output logic                              done
);

    localparam int CW = cvp_pkg::CW;
    localparam int PW = CW + cvp_pkg::DW + 2;
    localparam logic [CW:0] ONE_EXT = (CW+1)'(1) << FRAC_BITS;

    // stage A
    logic [cvp_pkg::LANES-1:0][CW-1:0] q;
    logic                              err_a;
    logic                              va_reg;
    logic                              ins_a_reg, err_a_reg;
    logic signed [CW:0]                sx_reg, sy_reg;
    logic [CW-1:0]                     dz_a_reg, iw_a_reg;

    always_comb
    begin
        logic [QW-1:0] mag;
        logic          ovp, ovn;
        err_a = ctl.wzero;
        for (int l = 0; l < cvp_pkg::LANES; l++)
        begin
            mag = nq[l];
            ovp = |mag[QW-1:CW-1];
            ovn = (|mag[QW-1:CW]) | (mag[CW-1] & (|mag[CW-2:0]));
            if (ctl.wzero)
            begin
                q[l] = ctl.nzero[l] ? '0 : (ctl.nneg[l] ? cvp_pkg::CMIN : cvp_pkg::CMAX);
            end
            else if (ctl.neg[l])
            begin
                q[l]  = ovn ? cvp_pkg::CMIN : CW'(-mag[CW-1:0]);
                err_a = err_a | ovn;
            end
            else
            begin
                q[l]  = ovp ? cvp_pkg::CMAX : mag[CW-1:0];
                err_a = err_a | ovp;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ins_a_reg <= ctl.in_volume;
        err_a_reg <= err_a;
        sx_reg    <= $signed({q[cvp_pkg::LANE_X][CW-1], q[cvp_pkg::LANE_X]} + ONE_EXT);
        sy_reg    <= $signed({q[cvp_pkg::LANE_Y][CW-1], q[cvp_pkg::LANE_Y]} + ONE_EXT);
        dz_a_reg  <= q[cvp_pkg::LANE_Z];
        iw_a_reg  <= q[cvp_pkg::LANE_ONE];
    end

    // stage B: scale
    logic                 vb_reg, ins_b_reg, err_b_reg;
    logic signed [PW-1:0] px_reg, py_reg;
    logic [CW-1:0]        dz_b_reg, iw_b_reg;

    always_ff @(posedge clk)
    begin
        ins_b_reg <= ins_a_reg;
        err_b_reg <= err_a_reg;
        px_reg    <= sx_reg * $signed({1'b0, device_width});
        py_reg    <= sy_reg * $signed({1'b0, device_height});
        dz_b_reg  <= dz_a_reg;
        iw_b_reg  <= iw_a_reg;
    end

    // stage C: halve toward zero, saturate
    logic signed [PW-1:0] hx, hy;
    logic                 ovx, ovy;
    cvp_pkg::result_t     res_reg, res_next;
    logic                 done_reg;

    always_comb
    begin
        hx  = (px_reg + $signed({{(PW-1){1'b0}}, px_reg[PW-1]})) >>> 1;
        hy  = (py_reg + $signed({{(PW-1){1'b0}}, py_reg[PW-1]})) >>> 1;
        ovx = !((&hx[PW-1:CW-1]) | ~(|hx[PW-1:CW-1]));
        ovy = !((&hy[PW-1:CW-1]) | ~(|hy[PW-1:CW-1]));
        res_next.inside_res  = ins_b_reg;
        res_next.device_x    = ovx ? (hx[PW-1] ? cvp_pkg::CMIN : cvp_pkg::CMAX) : hx[CW-1:0];
        res_next.device_y    = ovy ? (hy[PW-1] ? cvp_pkg::CMIN : cvp_pkg::CMAX) : hy[CW-1:0];
        res_next.depth       = dz_b_reg;
        res_next.inv_w       = iw_b_reg;
        res_next.range_error = err_b_reg | ovx | ovy;
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg   <= 1'b0;
            vb_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            va_reg   <= ctl.valid;
            vb_reg   <= va_reg;
            done_reg <= vb_reg;
        end
    end

    assign result = res_reg;
    assign done   = done_reg;

endmodule

// File: tb/testbench.sv
// Testbench for the clip test / perspective divide / viewport block.
class vertex_scoreboard;
    cvp_pkg::result_t           pending[$];
    logic [cvp_pkg::DW-1:0]     width_px;
    logic [cvp_pkg::DW-1:0]     height_px;
    int                         fails;

    function new();
        width_px  = cvp_pkg::WIDTH_RESET;
        height_px = cvp_pkg::HEIGHT_RESET;
        fails     = 0;
    endfunction

    // truncating fixed-point divide with saturation
    function longint fx_div(longint n, longint d, ref bit err);
        bit      neg;
        longint  an, ad, q0, r, frac, mag;
        longint  cmax_v, cmin_v;
        cmax_v = 64'sd2147483647;
        cmin_v = -64'sd2147483648;
        if (d == 0) begin
            err = 1;
            if (n > 0) return cmax_v;
            if (n < 0) return cmin_v;
            return 0;
        end
        neg  = (n < 0) != (d < 0);
        an   = (n < 0) ? -n : n;
        ad   = (d < 0) ? -d : d;
        q0   = an / ad;
        r    = an % ad;
        frac = 0;
        for (int i = 0; i < 16; i++) begin
            r    = r << 1;
            frac = frac << 1;
            if (r >= ad) begin
                r    = r - ad;
                frac = frac | 1;
            end
        end
        if (q0 > (64'sd1 << 15)) begin
            err = 1;
            return neg ? cmin_v : cmax_v;
        end
        mag = (q0 << 16) | frac;
        if (neg) begin
            if (mag > 64'sd2147483648) begin
                err = 1;
                return cmin_v;
            end
            return -mag;
        end
        if (mag > cmax_v) begin
            err = 1;
            return cmax_v;
        end
        return mag;
    endfunction

    function longint to_screen(longint ndc, longint scale, ref bit err);
        longint p;
        p = ((ndc + 65536) * scale) / 2;
        if (p > 64'sd2147483647) begin
            err = 1;
            return 64'sd2147483647;
        end
        if (p < -64'sd2147483648) begin
            err = 1;
            return -64'sd2147483648;
        end
        return p;
    endfunction

    function void note_vertex(cvp_pkg::vertex_t v);
        cvp_pkg::result_t r;
        bit      err;
        longint  x, y, z, w, nx, ny;
        x   = v.clip_x;
        y   = v.clip_y;
        z   = v.clip_z;
        w   = v.clip_w;
        err = 0;
        r.inside_res = x > -w && x < w && y > -w && y < w && z > 0 && z < w;
        nx = fx_div(x, w, err);
        ny = fx_div(y, w, err);
        r.depth    = cvp_pkg::CW'(fx_div(z, w, err));
        r.inv_w    = cvp_pkg::CW'(fx_div(65536, w, err));
        r.device_x = cvp_pkg::CW'(to_screen(nx, longint'(width_px), err));
        r.device_y = cvp_pkg::CW'(to_screen(ny, longint'(height_px), err));
        r.range_error = err;
        pending.push_back(r);
    endfunction

    function void check_result(cvp_pkg::result_t got);
        cvp_pkg::result_t e;
        if (pending.size() == 0) begin
            $display("%0t: unexpected word %h", $time, got);
            fails++;
            return;
        end
        e = pending.pop_front();
        if (got.inside_res != e.inside_res || got.device_x != e.device_x ||
            got.device_y != e.device_y || got.depth != e.depth ||
            got.inv_w != e.inv_w || got.range_error != e.range_error) begin
            $display("%0t: mismatch exp in=%b dx=%h dy=%h z=%h iw=%h err=%b",
                     $time, e.inside_res, e.device_x, e.device_y, e.depth, e.inv_w,
                     e.range_error);
            $display("%0t:          got in=%b dx=%h dy=%h z=%h iw=%h err=%b",
                     $time, got.inside_res, got.device_x, got.device_y, got.depth,
                     got.inv_w, got.range_error);
            fails++;
        end
    endfunction
endclass

module testbench;
    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    cvp_pkg::vertex_t       vertex;
    logic                   done;
    cvp_pkg::result_t       result;
    logic                   cfg_wr;
    logic                   cfg_addr;
    logic [cvp_pkg::DW-1:0] cfg_data;

    vertex_scoreboard sb;
    int idle_pct;

    clip_test_perspective_viewport i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .vertex   (vertex),
        .done     (done),
        .result   (result),
        .cfg_wr   (cfg_wr),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5000000;
        $display("FAILED: results differ");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(result);
    end

    task automatic send_vertex(cvp_pkg::vertex_t v);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start = 0;
            @(negedge clk);
        end
        start  = 1;
        vertex = v;
        while (busy)
            @(negedge clk);
        sb.note_vertex(v);
        @(negedge clk);
    endtask

    task automatic drain();
        start = 0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (60) @(negedge clk);
    endtask

    task automatic write_reg(logic addr, logic [cvp_pkg::DW-1:0] data);
        drain();
        cfg_wr   = 1;
        cfg_addr = addr;
        cfg_data = data;
        @(negedge clk);
        cfg_wr = 0;
        if (addr == cvp_pkg::REG_WIDTH)
            sb.width_px = data;
        else
            sb.height_px = data;
    endtask

    function automatic cvp_pkg::vertex_t mk(longint x, longint y, longint z, longint w);
        cvp_pkg::vertex_t v;
        v.clip_x = cvp_pkg::CW'(x);
        v.clip_y = cvp_pkg::CW'(y);
        v.clip_z = cvp_pkg::CW'(z);
        v.clip_w = cvp_pkg::CW'(w);
        return v;
    endfunction

    function automatic cvp_pkg::vertex_t rand_vertex();
        cvp_pkg::vertex_t v;
        longint  w, span;
        int      mode;
        mode = $urandom_range(0, 9);
        v = {$urandom, $urandom, $urandom, $urandom};
        if (mode <= 5) begin
            w = $urandom_range(1, 1 << ($urandom_range(1, 30)));
            if ($urandom_range(0, 7) == 0)
                w = -w;
            span = (w < 0 ? -w : w) + (w < 0 ? -w : w) / 4 + 1;
            v.clip_w = cvp_pkg::CW'(w);
            v.clip_x = cvp_pkg::CW'(longint'($urandom_range(0, 32'(2 * span))) - span);
            v.clip_y = cvp_pkg::CW'(longint'($urandom_range(0, 32'(2 * span))) - span);
            v.clip_z = cvp_pkg::CW'(longint'($urandom_range(0, 32'(span))) - span / 8);
        end else if (mode == 8) begin
            v.clip_w = cvp_pkg::CW'(longint'($urandom_range(0, 511)) - 256);
        end else if (mode == 9) begin
            v.clip_w = '0;
        end
        return v;
    endfunction

    task automatic random_run(int count);
        for (int i = 0; i < count; i++)
            send_vertex(rand_vertex());
    endtask

    initial
    begin
        sb       = new();
        rst_n    = 0;
        start    = 0;
        vertex   = '0;
        cfg_wr   = 0;
        cfg_addr = cvp_pkg::REG_WIDTH;
        cfg_data = '0;
        idle_pct = 36;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // directed: zero w, extremes, inside/outside, overflow
        send_vertex(mk(0, 0, 0, 0));
        send_vertex(mk(65536, -65536, 0, 0));
        send_vertex(mk(-2147483648, 2147483647, -1, 0));
        send_vertex(mk(0, 0, 32768, 65536));
        send_vertex(mk(32768, -32768, 16384, 65536));
        send_vertex(mk(65536, 0, 32768, 65536));
        send_vertex(mk(0, -65536, 65536, 65536));
        send_vertex(mk(0, 0, 0, 65536));
        send_vertex(mk(0, 0, 1, -65536));
        send_vertex(mk(2147483647, 2147483647, 2147483647, 2147483647));
        send_vertex(mk(-2147483648, -2147483648, -2147483648, -2147483648));
        send_vertex(mk(2147483647, -2147483648, 2147483647, 1));
        send_vertex(mk(-2147483648, 2147483647, -2147483648, -1));
        send_vertex(mk(-2147483648, 0, 65536, 65536));
        send_vertex(mk(2147483647, 2147483647, -2147483648, 2147483647));
        send_vertex(mk(1 << 30, -(1 << 30), 1 << 30, 1 << 15));
        send_vertex(mk(1, 2, 3, -2147483648));
        send_vertex(mk(65536, 65536, 65536, 2));
        send_vertex(mk(-65535, 65535, 65535, 65536));
        send_vertex(mk(32767 << 16, 0, 0, 65536));

        random_run(250);
        drain();
        idle_pct = 0;
        random_run(300);

        idle_pct = 36;
        write_reg(cvp_pkg::REG_WIDTH, cvp_pkg::DW'(1));
        write_reg(cvp_pkg::REG_HEIGHT, cvp_pkg::DW'(1));
        random_run(200);
        write_reg(cvp_pkg::REG_WIDTH, cvp_pkg::DW'(4096));
        write_reg(cvp_pkg::REG_HEIGHT, cvp_pkg::DW'(4096));
        random_run(200);
        write_reg(cvp_pkg::REG_WIDTH, cvp_pkg::DW'(0));
        write_reg(cvp_pkg::REG_HEIGHT, cvp_pkg::DW'(8191));
        random_run(200);
        write_reg(cvp_pkg::REG_WIDTH, cvp_pkg::DW'($urandom_range(1, 4096)));
        write_reg(cvp_pkg::REG_HEIGHT, cvp_pkg::DW'($urandom_range(1, 4096)));
        random_run(200);

        drain();
        if (sb.fails == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule

// File: sim.f
hdl/cvp_pkg.sv
hdl/cvp_cell.sv
hdl/cvp_post.sv
hdl/clip_test_perspective_viewport.sv
tb/testbench.sv
